@@ hdl/rse_pkg.sv @@
// Shared types and constants for the record stack engine.
// No dependencies; every other file but rse_ram imports this package.
package rse_pkg;

    localparam int STACK_DEPTH    = 16;
    localparam int PAYLOAD_BITS   = 64;
    localparam int ADDR_W         = $clog2(STACK_DEPTH);
    localparam int CNT_W          = $clog2(STACK_DEPTH + 1);
    localparam int OP_W           = 3;
    localparam int ID_W           = 32;
    localparam int PORT_PAYLOAD_W = 64;
    localparam int STATUS_W       = 3;
    localparam int POS_W          = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_DISPLAY = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_SORT    = 3'd4,
        OP_REVERSE = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOTHING   = 3'd4
    } t_status;

    // One stored record as it sits in the record memory.
    typedef struct packed {
        logic signed [ID_W-1:0]   id;
        logic [PAYLOAD_BITS-1:0]  payload;
    } t_rec;

    // Flags from the shared id comparator.
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

    // One result item as it leaves the block.
    typedef struct packed {
        t_status                    status;
        logic signed [ID_W-1:0]     id;
        logic [PORT_PAYLOAD_W-1:0]  payload;
        logic [POS_W-1:0]           position;
        logic                       last;
    } t_result;

endpackage

@@ hdl/rse_ifs.sv @@
// Valid/ready channel interfaces for the record stack engine.
// Depends on rse_pkg for the field widths.
interface rse_in_if;
    import rse_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic signed [ID_W-1:0]     rec_id;
    logic [PORT_PAYLOAD_W-1:0]  rec_payload;

    modport source (output valid, op, rec_id, rec_payload, input ready);
    modport sink   (input valid, op, rec_id, rec_payload, output ready);
endinterface

interface rse_out_if;
    import rse_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [ID_W-1:0]     out_id;
    logic [PORT_PAYLOAD_W-1:0]  out_payload;
    logic [POS_W-1:0]           out_position;
    logic                       last;

    modport source (output valid, status, out_id, out_payload, out_position, last,
                    input ready);
    modport sink   (input valid, status, out_id, out_payload, out_position, last,
                    output ready);
endinterface

@@ hdl/rse_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rse_cmp.sv @@
// Shared signed id comparator used by search and sort.
// Depends on rse_pkg.
module rse_cmp (
    input  logic signed [rse_pkg::ID_W-1:0] i_a,
    input  logic signed [rse_pkg::ID_W-1:0] i_b,
    output rse_pkg::t_cmp                   o_res
);
    import rse_pkg::*;

    assign o_res.gt = (i_a > i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

@@ hdl/record_stack_engine_top.sv @@
// Top level of the record stack engine: sequencer, record memory and output register.
// Depends on rse_pkg, rse_ifs, rse_ram and rse_cmp.
//
// The block keeps a bounded last-in first-out stack of records (signed id plus
// payload). Commands arrive on the i_in channel and results leave on o_out; a
// transfer happens on a rising edge where valid and ready are both high.
// Push, pop, search, sort and reverse each give one result; display gives one
// result per stored record, top first, with last set on the final one.
// Commands are taken one at a time: i_in.ready is high only while the sequencer
// is idle. All records live in one RAM with one read and one write port, and a
// single comparator serves search and sort. A finished result sits in the
// output register and the block may accept the next command meanwhile; when the
// receiver stalls, the sequencer holds its next result until the register is
// free. Reset empties the stack and marks the output register empty; record
// storage keeps stale data, which is never used since only entries below the
// record count are used.
module record_stack_engine_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rse_in_if.sink    i_in,
    rse_out_if.source o_out
);
    import rse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SORT_RDI,
        S_SORT_LDI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_SORT_WBI,
        S_REV_RDA,
        S_REV_RDB,
        S_REV_SWP,
        S_REV_WRB
    } t_state;

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [ADDR_W-1:0]      r_i, n_i;
    logic [ADDR_W-1:0]      r_j, n_j;
    logic signed [ID_W-1:0] r_key, n_key;
    t_rec                   r_cur, n_cur;
    t_result                r_res, n_res;
    logic                   r_more, n_more;
    t_result                r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   in_acc;
    logic                   out_free;
    logic                   last_i;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    t_rec                   ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    t_rec                   rd_rec;
    logic signed [ID_W-1:0] cmp_a;
    t_cmp                   cmp_res;

    // Storage slot of the record at depth d from the top.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [CNT_W-1:0] cnt,
                                                  input logic [ADDR_W-1:0] d);
        return ADDR_W'(cnt - CNT_W'(1) - CNT_W'(d));
    endfunction

    function automatic t_result res_rec(input t_status s, input t_rec rec,
                                        input logic [ADDR_W-1:0] d, input logic lst);
        t_result r;
        r.status   = s;
        r.id       = rec.id;
        r.payload  = PORT_PAYLOAD_W'(rec.payload);
        r.position = POS_W'(d);
        r.last     = lst;
        return r;
    endfunction

    function automatic t_result res_none(input t_status s);
        t_result r;
        r.status   = s;
        r.id       = '0;
        r.payload  = '0;
        r.position = '0;
        r.last     = 1'b1;
        return r;
    endfunction

    rse_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_rec)
    );

    // Sort compares the held record against the one just read; search compares
    // the sought id against it.
    assign cmp_a = (r_state == S_SORT_CMP) ? r_cur.id : r_key;

    rse_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (rd_rec.id),
        .o_res (cmp_res)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_i     = ((CNT_W'(r_i) + CNT_W'(1)) == r_count);

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.out_id       = r_out.id;
    assign o_out.out_payload  = r_out.payload;
    assign o_out.out_position = r_out.position;
    assign o_out.last         = r_out.last;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_key       = r_key;
        n_cur       = r_cur;
        n_res       = r_res;
        n_more      = r_more;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = slot_of(r_count, r_i);
        ram_wdata   = r_cur;
        ram_raddr   = slot_of(r_count, r_i);

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = t_op'(i_in.op);
                    n_key   = i_in.rec_id;
                    n_i     = '0;
                    n_more  = 1'b0;
                    n_res   = res_none(ST_NOTHING);
                    n_state = S_EMIT;
                    ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                    case (t_op'(i_in.op))
                        OP_PUSH: begin
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                n_res = res_none(ST_FULL);
                            end else begin
                                ram_we            = 1'b1;
                                ram_waddr         = ADDR_W'(r_count);
                                ram_wdata.id      = i_in.rec_id;
                                ram_wdata.payload = i_in.rec_payload[PAYLOAD_BITS-1:0];
                                n_count           = r_count + CNT_W'(1);
                                n_res = res_rec(ST_OK, ram_wdata, '0, 1'b1);
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_res = res_none(ST_EMPTY);
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                n_state = S_POP_WAIT;
                            end
                        end
                        OP_DISPLAY, OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_res = res_none(ST_EMPTY);
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_SORT: begin
                            if (r_count >= CNT_W'(2)) begin
                                n_state = S_SORT_RDI;
                            end
                        end
                        OP_REVERSE: begin
                            if (r_count >= CNT_W'(2)) begin
                                n_state = S_REV_RDA;
                            end
                        end
                        default: begin
                            n_res = res_none(ST_NOTHING);
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    if (r_more) begin
                        n_i     = r_i + ADDR_W'(1);
                        n_more  = 1'b0;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_POP_WAIT: begin
                n_res   = res_rec(ST_OK, rd_rec, '0, 1'b1);
                n_state = S_EMIT;
            end
            S_SCAN_RD: begin
                ram_raddr = slot_of(r_count, r_i);
                n_state   = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_op == OP_DISPLAY) begin
                    n_res   = res_rec(ST_OK, rd_rec, r_i, last_i);
                    n_more  = !last_i;
                    n_state = S_EMIT;
                end else if (cmp_res.eq) begin
                    n_res   = res_rec(ST_OK, rd_rec, r_i, 1'b1);
                    n_state = S_EMIT;
                end else if (last_i) begin
                    n_res   = res_none(ST_NOT_FOUND);
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i + ADDR_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SORT_RDI: begin
                ram_raddr = slot_of(r_count, r_i);
                n_state   = S_SORT_LDI;
            end
            S_SORT_LDI: begin
                n_cur   = rd_rec;
                n_j     = r_i + ADDR_W'(1);
                n_state = S_SORT_RDJ;
            end
            S_SORT_RDJ: begin
                ram_raddr = slot_of(r_count, r_j);
                n_state   = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                // A smaller id below the held record: the held record moves
                // down to depth j and the smaller one is carried on.
                if (cmp_res.gt) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(r_count, r_j);
                    ram_wdata = r_cur;
                    n_cur     = rd_rec;
                end
                if ((CNT_W'(r_j) + CNT_W'(1)) == r_count) begin
                    n_state = S_SORT_WBI;
                end else begin
                    n_j     = r_j + ADDR_W'(1);
                    n_state = S_SORT_RDJ;
                end
            end
            S_SORT_WBI: begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(r_count, r_i);
                ram_wdata = r_cur;
                if ((CNT_W'(r_i) + CNT_W'(2)) == r_count) begin
                    n_res   = res_none(ST_OK);
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i + ADDR_W'(1);
                    n_state = S_SORT_RDI;
                end
            end
            S_REV_RDA: begin
                ram_raddr = r_i;
                n_state   = S_REV_RDB;
            end
            S_REV_RDB: begin
                ram_raddr = slot_of(r_count, r_i);
                n_cur     = rd_rec;
                n_state   = S_REV_SWP;
            end
            S_REV_SWP: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = rd_rec;
                n_state   = S_REV_WRB;
            end
            S_REV_WRB: begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(r_count, r_i);
                ram_wdata = r_cur;
                if ((CNT_W'(r_i) + CNT_W'(1)) == (r_count >> 1)) begin
                    n_res   = res_none(ST_OK);
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i + ADDR_W'(1);
                    n_state = S_REV_RDA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
        r_op  <= n_op;
        r_i   <= n_i;
        r_j   <= n_j;
        r_key <= n_key;
        r_cur <= n_cur;
        r_res <= n_res;
        r_out <= n_out;
    end

`ifndef ASSERT_OFF
    // The record count never passes the stack depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("record count exceeds stack depth");

    // A push into a stack with room grows the count by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (t_op'(i_in.op) == OP_PUSH) && (r_count < CNT_W'(STACK_DEPTH))
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not grow the stack");

    // While idle, the memory is written only by an accepted push.
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && (r_state == S_IDLE) |-> in_acc)
        else $error("memory written while idle without a push");

    // Sort and reverse move records around without changing their number.
    a_reorder_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT_CMP) || (r_state == S_REV_SWP) |-> $stable(r_count))
        else $error("record count changed during reordering");
`endif

endmodule

@@ tb/record_stack_engine_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for record_stack_engine_top: a command driver, a result
// monitor and a predictor that keeps its own copy of the record stack.
// Depends on rse_pkg, the rse_in_if/rse_out_if interfaces and the block's RTL.
module record_stack_engine_top_tb;
    import rse_pkg::*;

    // Op codes six and seven are not decoded by the block; they must still
    // produce a single "nothing to do" result.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [ID_W-1:0] ID_MIN = {1'b1, {(ID_W-1){1'b0}}};
    localparam logic signed [ID_W-1:0] ID_MAX = {1'b0, {(ID_W-1){1'b1}}};

    localparam int RANDOM_ITEMS = 96;
    // The idle limit leaves wide margin above both a full sort of sixteen records
    // and the long output hold below.
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 40;
    localparam int RECENT_KEEP  = 32;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [ID_W-1:0]    id;
        logic [PORT_PAYLOAD_W-1:0] payload;
    } t_stack_cmd;

    // Output-side stall patterns, cycled through in turn.
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_PATTERN
    } t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rse_in_if  in_ch();
    rse_out_if out_ch();

    record_stack_engine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Commands waiting to be driven, and the results the stack model predicts.
    t_stack_cmd pending_cmds[$];
    t_result    expected_results[$];

    // Stack model: records stored bottom first, so the top is at rec_count - 1.
    t_rec stack_mem[STACK_DEPTH];
    int   rec_count = 0;

    // Generator-side bookkeeping. The record count depends only on pushes and
    // pops, so the generator can follow it exactly while building sequences.
    int                     gen_count = 0;
    logic signed [ID_W-1:0] recent_ids[$];

    int cmds_total    = 0;
    int cmds_accepted = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    // ------------------------------------------------------------------
    // Stack model: applies one accepted command and queues its results.
    // ------------------------------------------------------------------
    function automatic void predict_results(input t_stack_cmd c);
        t_result                r;
        t_rec                   tmp;
        int                     d;
        int                     e;
        int                     top_slot;
        int                     low_slot;
        bit                     found;
        logic signed [ID_W-1:0] id_a;
        logic signed [ID_W-1:0] id_b;
        r      = '0;
        r.last = 1'b1;
        case (c.op)
            OP_PUSH: begin
                if (rec_count >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_mem[rec_count] = '{id: c.id, payload: c.payload[PAYLOAD_BITS-1:0]};
                    rec_count++;
                    r.status  = ST_OK;
                    r.id      = c.id;
                    r.payload = c.payload[PAYLOAD_BITS-1:0];
                end
                expected_results.push_back(r);
            end
            OP_POP: begin
                if (rec_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    rec_count--;
                    r.status  = ST_OK;
                    r.id      = stack_mem[rec_count].id;
                    r.payload = stack_mem[rec_count].payload;
                end
                expected_results.push_back(r);
            end
            OP_DISPLAY: begin
                if (rec_count == 0) begin
                    r.status = ST_EMPTY;
                    expected_results.push_back(r);
                end else begin
                    // One result per record, top first; only the bottom one ends the list.
                    for (d = 0; d < rec_count; d++) begin
                        r.status   = ST_OK;
                        r.id       = stack_mem[rec_count - 1 - d].id;
                        r.payload  = stack_mem[rec_count - 1 - d].payload;
                        r.position = d[POS_W-1:0];
                        r.last     = (d == rec_count - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            OP_SEARCH: begin
                found = 1'b0;
                if (rec_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOT_FOUND;
                    for (d = 0; d < rec_count && !found; d++) begin
                        if (stack_mem[rec_count - 1 - d].id == c.id) begin
                            found      = 1'b1;
                            r.status   = ST_OK;
                            r.id       = stack_mem[rec_count - 1 - d].id;
                            r.payload  = stack_mem[rec_count - 1 - d].payload;
                            r.position = d[POS_W-1:0];
                        end
                    end
                end
                expected_results.push_back(r);
            end
            OP_SORT: begin
                if (rec_count < 2) begin
                    r.status = ST_NOTHING;
                end else begin
                    // Exchange sort by depth: the record at depth d trades places with
                    // any deeper record whose id is strictly smaller (signed).
                    for (d = 0; d < rec_count; d++) begin
                        for (e = d + 1; e < rec_count; e++) begin
                            top_slot = rec_count - 1 - d;
                            low_slot = rec_count - 1 - e;
                            id_a     = stack_mem[top_slot].id;
                            id_b     = stack_mem[low_slot].id;
                            if (id_a > id_b) begin
                                tmp                 = stack_mem[top_slot];
                                stack_mem[top_slot] = stack_mem[low_slot];
                                stack_mem[low_slot] = tmp;
                            end
                        end
                    end
                    r.status = ST_OK;
                end
                expected_results.push_back(r);
            end
            OP_REVERSE: begin
                if (rec_count < 2) begin
                    r.status = ST_NOTHING;
                end else begin
                    for (d = 0; d < rec_count / 2; d++) begin
                        tmp                         = stack_mem[d];
                        stack_mem[d]                = stack_mem[rec_count - 1 - d];
                        stack_mem[rec_count - 1 - d] = tmp;
                    end
                    r.status = ST_OK;
                end
                expected_results.push_back(r);
            end
            default: begin
                r.status = ST_NOTHING;
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic signed [ID_W-1:0] random_id();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            case ($urandom_range(0, 3))
                0:       return ID_MIN;
                1:       return ID_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end else if (pick < 6) begin
            // A narrow band gives plenty of duplicate ids for search and sort.
            return $urandom_range(0, 15) - 8;
        end
        return $urandom;
    endfunction

    function automatic logic [PORT_PAYLOAD_W-1:0] random_payload();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Ids already pushed, so that searches hit more often than chance allows.
    function automatic logic signed [ID_W-1:0] search_id();
        if (recent_ids.size() == 0 || $urandom_range(0, 3) == 0)
            return random_id();
        return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    endfunction

    function automatic void add_cmd(input logic [OP_W-1:0] op,
                                    input logic signed [ID_W-1:0] id,
                                    input logic [PORT_PAYLOAD_W-1:0] payload);
        pending_cmds.push_back('{op, id, payload});
        if (op == OP_PUSH) begin
            if (gen_count < STACK_DEPTH)
                gen_count++;
            recent_ids.push_back(id);
            if (recent_ids.size() > RECENT_KEEP)
                void'(recent_ids.pop_front());
        end else if (op == OP_POP && gen_count > 0) begin
            gen_count--;
        end
    endfunction

    // ------------------------------------------------------------------
    // Command driver: bursts of random length separated by random gaps.
    // A command stays on the channel until its transfer completes.
    // ------------------------------------------------------------------
    t_stack_cmd cur_cmd;
    int         burst_left = 1;
    int         gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_results(cur_cmd);
                cmds_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.op          <= cur_cmd.op;
                    in_ch.rec_id      <= cur_cmd.id;
                    in_ch.rec_payload <= cur_cmd.payload;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: rotates through free-running, coin-flip and fixed
    // stall patterns. Once, after enough results, it holds ready low for a
    // long stretch so the output register fills and the input side backs up.
    // ------------------------------------------------------------------
    int       rx_cycle  = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    t_rx_mode rx_mode;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            rx_cycle++;
            rx_mode = t_rx_mode'((rx_cycle / 80) % 3);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:  out_ch.ready <= 1'b1;
                    RX_COIN:  out_ch.ready <= ($urandom_range(0, 1) == 1);
                    default:  out_ch.ready <= ((rx_cycle % 7) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every transfer is checked against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [PORT_PAYLOAD_W-1:0] want,
                                        input logic [PORT_PAYLOAD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with no prediction pending: status %0d id 'h%0h",
                       out_ch.status, out_ch.out_id);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", PORT_PAYLOAD_W'(want.status),
                            PORT_PAYLOAD_W'(out_ch.status));
                check_field("out_id", PORT_PAYLOAD_W'(want.id),
                            PORT_PAYLOAD_W'(out_ch.out_id));
                check_field("out_payload", want.payload, out_ch.out_payload);
                check_field("out_position", PORT_PAYLOAD_W'(want.position),
                            PORT_PAYLOAD_W'(out_ch.out_position));
                check_field("last", PORT_PAYLOAD_W'(want.last),
                            PORT_PAYLOAD_W'(out_ch.last));
            end
        end
    end

    // Count clocks without any transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int seq_len;
        int random_end;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_PUSH;
        in_ch.rec_id      = '0;
        in_ch.rec_payload = '0;
        out_ch.ready      = 1'b0;

        // Directed part. Every op on an empty stack first, then sort and
        // reverse with a single record, then duplicates and extreme values.
        add_cmd(OP_POP, 0, 0);
        add_cmd(OP_DISPLAY, 0, 0);
        add_cmd(OP_SEARCH, 5, 0);
        add_cmd(OP_SORT, 0, 0);
        add_cmd(OP_REVERSE, 0, 0);
        add_cmd(OP_SPARE_LO, ID_MAX, '1);
        add_cmd(OP_SPARE_HI, ID_MIN, '1);
        add_cmd(OP_PUSH, ID_MIN, '0);
        add_cmd(OP_SORT, 0, 0);
        add_cmd(OP_REVERSE, 0, 0);
        add_cmd(OP_PUSH, ID_MAX, '1);
        add_cmd(OP_PUSH, -1, 64'h5555_5555_5555_5555);
        add_cmd(OP_PUSH, 0, 64'hAAAA_AAAA_AAAA_AAAA);
        add_cmd(OP_PUSH, -1, 64'h0123_4567_89AB_CDEF);
        // Two records share id -1; the search must return the upper one.
        add_cmd(OP_SEARCH, -1, 0);
        add_cmd(OP_SEARCH, 12345, 0);
        add_cmd(OP_DISPLAY, 0, 0);
        add_cmd(OP_SORT, 0, 0);
        add_cmd(OP_DISPLAY, 0, 0);
        add_cmd(OP_REVERSE, 0, 0);
        add_cmd(OP_DISPLAY, 0, 0);
        add_cmd(OP_POP, 0, 0);
        add_cmd(OP_SEARCH, ID_MIN, 0);

        // Random part, built from short well-formed sequences plus some noise.
        random_end = pending_cmds.size() + RANDOM_ITEMS;
        while (pending_cmds.size() < random_end) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // Fill run; a third of the time it goes to full and one past it.
                    if ($urandom_range(0, 2) == 0)
                        seq_len = STACK_DEPTH + 1 - gen_count;
                    else
                        seq_len = $urandom_range(1, 4);
                    repeat (seq_len) add_cmd(OP_PUSH, random_id(), random_payload());
                end
                3: begin
                    // Drain, sometimes with one pop past empty.
                    seq_len = gen_count + $urandom_range(0, 1);
                    if (seq_len > 6 && $urandom_range(0, 1) == 1)
                        seq_len = $urandom_range(1, 6);
                    repeat (seq_len) add_cmd(OP_POP, random_id(), random_payload());
                end
                4: begin
                    add_cmd(OP_SORT, random_id(), random_payload());
                    add_cmd(OP_DISPLAY, random_id(), random_payload());
                end
                5: begin
                    add_cmd(OP_REVERSE, random_id(), random_payload());
                    add_cmd(OP_DISPLAY, random_id(), random_payload());
                end
                6, 7: begin
                    add_cmd(OP_SEARCH, search_id(), random_payload());
                end
                8: begin
                    add_cmd(OP_DISPLAY, random_id(), random_payload());
                end
                default: begin
                    add_cmd(OP_W'($urandom_range(0, 7)), random_id(), random_payload());
                end
            endcase
        end
        cmds_total = pending_cmds.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < cmds_total || expected_results.size() != 0)
            @(posedge i_clk);
        // Any stray result after the last expected one is caught by the monitor.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
